/* src/gtdac_pkg.sv */
package gtdac_pkg;

   localparam int IndexWidth = 11;
   localparam int AmpWidth = 24;
   localparam int WordWidth = 22;
   localparam int CodeWidth = 16;
   localparam int RampWidth = 7;
   localparam int NumWidth = 32;
   localparam int QuoWidth = 22;

   localparam int DefaultWaveLength = 2000;

   // Configuration register indexes.
   localparam logic [2:0] REG_MODE = 3'd0;
   localparam logic [2:0] REG_READOUT_AMP = 3'd1;
   localparam logic [2:0] REG_PHASE_AMP = 3'd2;
   localparam logic [2:0] REG_OFFSET_X = 3'd3;
   localparam logic [2:0] REG_OFFSET_Y = 3'd4;
   localparam logic [2:0] REG_OFFSET_Z = 3'd5;
   localparam logic [2:0] REG_OFFSET_Z2 = 3'd6;

   // Table modes.
   localparam logic [2:0] MODE_ZERO_DISABLED = 3'd0;
   localparam logic [2:0] MODE_ZERO_ENABLED = 3'd1;
   localparam logic [2:0] MODE_OFFSET_ENABLED = 3'd2;
   localparam logic [2:0] MODE_ECHO = 3'd3;
   localparam logic [2:0] MODE_CLEARED = 3'd4;

   localparam logic [WordWidth-1:0] LEVEL_FLAG_WORD = 22'h100000;
   localparam logic [WordWidth-1:0] CTRL_ENABLE_WORD = 22'h200002;
   localparam logic [WordWidth-1:0] CTRL_DISABLE_WORD = 22'h20000E;

   // floor(num / 5120) = floor((num >>> 10) / 5). The quotient is made
   // non-negative by a bias of 5 * 2^19, which vanishes in the low 16 bits.
   localparam logic [QuoWidth-1:0] QUO_BIAS = 22'd2621440;
   localparam logic [22:0] RECIP_FIVE = 23'd6710887;
   localparam int RecipShift = 25;

   typedef enum logic [2:0] {
      KIND_ZERO,
      KIND_LEVEL,
      KIND_FLAG,
      KIND_ENABLE,
      KIND_DISABLE
   } word_kind_type;

   typedef struct packed {
      word_kind_type kind;
      logic signed [RampWidth-1:0] ramp_x;
      logic signed [RampWidth-1:0] ramp_y;
   } sample_ctrl_type;

endpackage

/* src/gtdac_decode.sv */
module gtdac_decode import gtdac_pkg::*; #(
   parameter int WAVE_LENGTH = DefaultWaveLength
) (
   input  logic                  clock,
   input  logic                  advance,
   input  logic [IndexWidth-1:0] sample_index,
   input  logic [2:0]            mode,
   output sample_ctrl_type       ctrl
);

   sample_ctrl_type ctrl_ff;
   sample_ctrl_type ctrl_in;
   logic [2:0] mode_eff;
   logic signed [IndexWidth:0] ii;
   logic beyond_end;

   assign ii = signed'({1'b0, sample_index});
   assign beyond_end = {1'b0, sample_index} >= (IndexWidth+1)'(WAVE_LENGTH);
   assign mode_eff = (mode > MODE_CLEARED) ? MODE_ZERO_DISABLED : mode;

   always_comb begin
      ctrl_in.kind = KIND_ZERO;
      ctrl_in.ramp_x = '0;
      ctrl_in.ramp_y = '0;

      priority if (beyond_end || mode_eff == MODE_CLEARED) begin
         ctrl_in.kind = KIND_ZERO;
      end else if (sample_index == '0) begin
         if (mode_eff == MODE_ZERO_DISABLED || mode_eff == MODE_ZERO_ENABLED) begin
            ctrl_in.kind = KIND_FLAG;
         end else begin
            ctrl_in.kind = KIND_LEVEL;
         end
      end else if (sample_index == IndexWidth'(1)) begin
         ctrl_in.kind = (mode_eff == MODE_ZERO_DISABLED) ? KIND_DISABLE : KIND_ENABLE;
      end else if (mode_eff == MODE_ECHO) begin
         ctrl_in.kind = KIND_LEVEL;
      end else begin
         ctrl_in.kind = KIND_ZERO;
      end

      // Ramp multipliers of the readout and phase-encode trapezoids.
      if (mode_eff == MODE_ECHO && sample_index > IndexWidth'(1)) begin
         priority if (ii < 22) begin
            ctrl_in.ramp_x = RampWidth'(2 * (ii - 1));
            ctrl_in.ramp_y = RampWidth'(ii - 1);
         end else if (ii < 82) begin
            ctrl_in.ramp_x = RampWidth'(40);
            ctrl_in.ramp_y = RampWidth'(20);
         end else if (ii < 102) begin
            ctrl_in.ramp_x = RampWidth'(2 * (101 - ii));
            ctrl_in.ramp_y = RampWidth'(101 - ii);
         end else if (ii < 122) begin
            ctrl_in.ramp_x = RampWidth'(101 - ii);
         end else if (ii < 422) begin
            ctrl_in.ramp_x = -RampWidth'(20);
         end else if (ii < 442) begin
            ctrl_in.ramp_x = RampWidth'(ii - 441);
         end else begin
            ctrl_in.ramp_x = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctrl_ff <= ctrl_in;
      end
   end

   assign ctrl = ctrl_ff;

endmodule

/* src/gtdac_level.sv */
module gtdac_level import gtdac_pkg::*; (
   input  logic                        clock,
   input  logic                        advance,
   input  logic signed [RampWidth-1:0] ramp,
   input  logic signed [AmpWidth-1:0]  amplitude,
   input  logic signed [AmpWidth-1:0]  offset,
   output logic [CodeWidth-1:0]        code
);

   logic signed [NumWidth-1:0] num_ff, num_in;
   logic [QuoWidth-1:0] quo_ff, quo_in;
   logic [CodeWidth-1:0] code_ff, code_in;
   logic [QuoWidth+22:0] recip_prod;

   // Twenty times the channel level in Q8.
   assign num_in = NumWidth'(offset) * NumWidth'(20)
                 + NumWidth'(ramp) * NumWidth'(amplitude);

   assign quo_in = num_ff[NumWidth-1:10] + QUO_BIAS;

   assign recip_prod = quo_ff * RECIP_FIVE;
   assign code_in = recip_prod[RecipShift+CodeWidth-1:RecipShift];

   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff <= num_in;
         quo_ff <= quo_in;
         code_ff <= code_in;
      end
   end

   assign code = code_ff;

endmodule

/* src/gradient_trapezoid_dac_word_generator_top.sv */
// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  tdata: sample_index
// rsp       out        rsp_tvalid/rsp_tready  tdata: word_x, word_y, word_z, word_z2
// csr       in         csr_valid/csr_ready    csr_index, csr_data
//
// One request enters per clock while the output is not stalled.
// The four stages are index decode, offset plus ramp times amplitude, the
// shift and bias, and the reciprocal multiply that divides by five.
// Reset clears the valid bits and all configuration registers to zero.
// A stalled result freezes the whole pipeline; req_tready falls only then.
module gradient_trapezoid_dac_word_generator_top import gtdac_pkg::*; #(
   parameter int WAVE_LENGTH = DefaultWaveLength
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,  // [10:0] sample_index, [15:11] zero
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [87:0]  rsp_tdata,  // [21:0] word_x, [43:22] word_y,
                                    // [65:44] word_z, [87:66] word_z2
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [23:0]  csr_data
);

   logic [2:0] mode_ff;
   logic signed [AmpWidth-1:0] ro_ff, pe_ff, ox_ff, oy_ff, oz_ff, oz2_ff;
   logic [3:0] valid_ff, valid_in;
   word_kind_type kind2_ff, kind3_ff, kind4_ff;
   sample_ctrl_type ctrl;
   logic advance;
   logic [CodeWidth-1:0] code_x, code_y, code_z, code_z2;
   logic [WordWidth-1:0] word_x, word_y, word_z, word_z2;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
         ro_ff <= '0;
         pe_ff <= '0;
         ox_ff <= '0;
         oy_ff <= '0;
         oz_ff <= '0;
         oz2_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_MODE:        mode_ff <= csr_data[2:0];
            REG_READOUT_AMP: ro_ff <= signed'(csr_data);
            REG_PHASE_AMP:   pe_ff <= signed'(csr_data);
            REG_OFFSET_X:    ox_ff <= signed'(csr_data);
            REG_OFFSET_Y:    oy_ff <= signed'(csr_data);
            REG_OFFSET_Z:    oz_ff <= signed'(csr_data);
            REG_OFFSET_Z2:   oz2_ff <= signed'(csr_data);
            default: ;
         endcase
      end
   end

   assign advance = !valid_ff[3] || rsp_tready;
   assign req_tready = advance;
   assign valid_in = {valid_ff[2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         kind2_ff <= ctrl.kind;
         kind3_ff <= kind2_ff;
         kind4_ff <= kind3_ff;
      end
   end

   gtdac_decode #(
      .WAVE_LENGTH(WAVE_LENGTH)
   ) u_decode (
      .clock       (clock),
      .advance     (advance),
      .sample_index(req_tdata[IndexWidth-1:0]),
      .mode        (mode_ff),
      .ctrl        (ctrl)
   );

   gtdac_level u_level_x (
      .clock(clock), .advance(advance), .ramp(ctrl.ramp_x),
      .amplitude(ro_ff), .offset(ox_ff), .code(code_x)
   );

   gtdac_level u_level_y (
      .clock(clock), .advance(advance), .ramp(ctrl.ramp_y),
      .amplitude(pe_ff), .offset(oy_ff), .code(code_y)
   );

   gtdac_level u_level_z (
      .clock(clock), .advance(advance), .ramp('0),
      .amplitude('0), .offset(oz_ff), .code(code_z)
   );

   gtdac_level u_level_z2 (
      .clock(clock), .advance(advance), .ramp('0),
      .amplitude('0), .offset(oz2_ff), .code(code_z2)
   );

   always_comb begin
      unique case (kind4_ff)
         KIND_LEVEL: begin
            word_x = {2'b01, code_x, 4'b0000};
            word_y = {2'b01, code_y, 4'b0000};
            word_z = {2'b01, code_z, 4'b0000};
            word_z2 = {2'b01, code_z2, 4'b0000};
         end
         KIND_FLAG: begin
            word_x = LEVEL_FLAG_WORD;
            word_y = LEVEL_FLAG_WORD;
            word_z = LEVEL_FLAG_WORD;
            word_z2 = LEVEL_FLAG_WORD;
         end
         KIND_ENABLE: begin
            word_x = CTRL_ENABLE_WORD;
            word_y = CTRL_ENABLE_WORD;
            word_z = CTRL_ENABLE_WORD;
            word_z2 = CTRL_ENABLE_WORD;
         end
         KIND_DISABLE: begin
            word_x = CTRL_DISABLE_WORD;
            word_y = CTRL_DISABLE_WORD;
            word_z = CTRL_DISABLE_WORD;
            word_z2 = CTRL_DISABLE_WORD;
         end
         default: begin
            word_x = '0;
            word_y = '0;
            word_z = '0;
            word_z2 = '0;
         end
      endcase
   end

   assign rsp_tvalid = valid_ff[3];
   assign rsp_tdata = {word_z2, word_z, word_y, word_x};

endmodule

/* src/gtdac_checker.sv */
module gtdac_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [87:0] rsp_tdata
);

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // The request side is held back only by a stalled result.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request refused without an output stall");

   // With the output side free, an accepted request reaches the output.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready
      |=> rsp_tvalid)
      else $error("result missing after pipeline latency");

   // Nothing is shown in the cycle after a reset edge.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown right after reset");

endmodule

bind gradient_trapezoid_dac_word_generator_top gtdac_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

/* tb/sv/gtdac_tb_pkg.sv */
package gtdac_tb_pkg;
   import gtdac_pkg::*;

   localparam int RampSteps = 20;
   // A level is kept as 20 times its Q8 value, so one DAC code is 20 * 256 of it.
   localparam longint LevelDivisor = RampSteps * 256;

   typedef struct packed {
      logic [WordWidth-1:0] word_z2;
      logic [WordWidth-1:0] word_z;
      logic [WordWidth-1:0] word_y;
      logic [WordWidth-1:0] word_x;
   } dac_words_type;

   typedef struct {
      logic [IndexWidth-1:0] sample_index;
      dac_words_type         words;
   } expected_words_type;

   class dac_word_scoreboard;
      logic [2:0]                 mode;
      logic signed [AmpWidth-1:0] ro_amp;
      logic signed [AmpWidth-1:0] pe_amp;
      logic signed [AmpWidth-1:0] off_x;
      logic signed [AmpWidth-1:0] off_y;
      logic signed [AmpWidth-1:0] off_z;
      logic signed [AmpWidth-1:0] off_z2;
      expected_words_type         pending_words[$];
      int                         errors;
      int                         checked;

      function new();
         mode = MODE_ZERO_DISABLED;
         ro_amp = '0;
         pe_amp = '0;
         off_x = '0;
         off_y = '0;
         off_z = '0;
         off_z2 = '0;
         errors = 0;
         checked = 0;
      endfunction

      function void write_reg(logic [2:0] index, logic [AmpWidth-1:0] data);
         case (index)
            REG_MODE: mode = data[2:0];
            REG_READOUT_AMP: ro_amp = data;
            REG_PHASE_AMP: pe_amp = data;
            REG_OFFSET_X: off_x = data;
            REG_OFFSET_Y: off_y = data;
            REG_OFFSET_Z: off_z = data;
            REG_OFFSET_Z2: off_z2 = data;
            default: ;
         endcase
      endfunction

      function logic [WordWidth-1:0] level_word(longint num);
         longint               q;
         logic [CodeWidth-1:0] code;
         q = num / LevelDivisor;
         if (num % LevelDivisor < 0) q = q - 1;
         code = q[CodeWidth-1:0];
         return LEVEL_FLAG_WORD | {2'b00, code, 4'b0000};
      endfunction

      function longint readout_term(longint i, longint ro);
         if (i < 22) return (i - 1) * 2 * ro;
         if (i < 82) return 2 * RampSteps * ro;
         if (i < 102) return (101 - i) * 2 * ro;
         if (i < 122) return -(i - 101) * ro;
         if (i < 422) return -RampSteps * ro;
         if (i < 442) return -(441 - i) * ro;
         return 0;
      endfunction

      function longint phase_term(longint i, longint pe);
         if (i < 22) return (i - 1) * pe;
         if (i < 82) return RampSteps * pe;
         if (i < 102) return (101 - i) * pe;
         return 0;
      endfunction

      function dac_words_type table_entry(logic [IndexWidth-1:0] sample_index);
         dac_words_type w;
         logic [2:0] m;
         longint     i;
         w = '0;
         m = mode;
         i = longint'(sample_index);
         // Undefined modes behave as the disabled zero table.
         if (m > MODE_CLEARED) m = MODE_ZERO_DISABLED;
         if (sample_index >= DefaultWaveLength || m == MODE_CLEARED) return w;
         if (sample_index == 0) begin
            if (m == MODE_ZERO_DISABLED || m == MODE_ZERO_ENABLED) begin
               w = {4{LEVEL_FLAG_WORD}};
            end else begin
               w.word_x = level_word(RampSteps * longint'(off_x));
               w.word_y = level_word(RampSteps * longint'(off_y));
               w.word_z = level_word(RampSteps * longint'(off_z));
               w.word_z2 = level_word(RampSteps * longint'(off_z2));
            end
         end else if (sample_index == 1) begin
            w = (m == MODE_ZERO_DISABLED) ? {4{CTRL_DISABLE_WORD}} : {4{CTRL_ENABLE_WORD}};
         end else if (m == MODE_ECHO) begin
            w.word_x = level_word(RampSteps * longint'(off_x)
                                  + readout_term(i, longint'(ro_amp)));
            w.word_y = level_word(RampSteps * longint'(off_y)
                                  + phase_term(i, longint'(pe_amp)));
            w.word_z = level_word(RampSteps * longint'(off_z));
            w.word_z2 = level_word(RampSteps * longint'(off_z2));
         end
         return w;
      endfunction

      function void note_request(logic [IndexWidth-1:0] sample_index);
         expected_words_type e;
         e.sample_index = sample_index;
         e.words = table_entry(sample_index);
         pending_words.push_back(e);
      endfunction

      function void compare_word(string name, logic [IndexWidth-1:0] sample_index,
                                 logic [WordWidth-1:0] exp_w, logic [WordWidth-1:0] act_w);
         if (act_w !== exp_w) begin
            $error("%s at index %0d: expected 0x%06h, actual 0x%06h",
                   name, sample_index, exp_w, act_w);
            errors++;
         end
      endfunction

      function void check_result(dac_words_type act);
         expected_words_type e;
         if (pending_words.size() == 0) begin
            $error("unexpected result 0x%022h with no request outstanding", act);
            errors++;
            return;
         end
         e = pending_words.pop_front();
         checked++;
         compare_word("word_x", e.sample_index, e.words.word_x, act.word_x);
         compare_word("word_y", e.sample_index, e.words.word_y, act.word_y);
         compare_word("word_z", e.sample_index, e.words.word_z, act.word_z);
         compare_word("word_z2", e.sample_index, e.words.word_z2, act.word_z2);
      endfunction

      function void close_out();
         if (pending_words.size() != 0) begin
            $error("%0d results never arrived", pending_words.size());
            errors++;
         end
      endfunction
   endclass

endpackage

/* tb/sv/tb.sv */
module tb;
   import gtdac_pkg::*;
   import gtdac_tb_pkg::*;

   localparam logic [2:0] REG_SPARE = 3'd7;
   localparam logic [2:0] MODE_UNDEFINED = 3'd5;
   localparam int NumPhases = 24;
   localparam int ItemsPerPhase = 53;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [15:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [87:0]  rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [23:0]  csr_data = '0;

   logic         quiet = 1'b0;
   logic [23:0]  setting [7];
   int           settings_used = 0;

   dac_word_scoreboard sb = new();

   gradient_trapezoid_dac_word_generator_top u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= quiet || ($urandom_range(99) >= 13);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_request(req_tdata[IndexWidth-1:0]);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      end
   end

   task automatic write_reg(input logic [2:0] index, input logic [23:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(index, data);
   endtask

   // Writes the whole register set; only called while nothing is in flight.
   task automatic configure(input bit with_spare);
      if (with_spare) write_reg(REG_SPARE, 24'($urandom));
      for (int r = REG_MODE; r <= REG_OFFSET_Z2; r++) write_reg(3'(r), setting[r]);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic send_index(input logic [IndexWidth-1:0] sample_index);
      while (!quiet && $urandom_range(99) < 13) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, sample_index};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending_words.size() != 0);
   endtask

   function automatic logic [23:0] pick_level();
      case ($urandom_range(7))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'h000000;
         3: return 24'hFFFFFF;
         4: return 24'($urandom_range(4095));
         5: return 24'(-int'($urandom_range(4095)));
         default: return 24'($urandom);
      endcase
   endfunction

   // Most requests walk the echo waveform; the rest hit the control words,
   // the end of the table, the indices past it, or any index at all.
   function automatic logic [IndexWidth-1:0] pick_index();
      int r;
      r = $urandom_range(99);
      if (r < 65) return 11'($urandom_range(460));
      if (r < 75) return 11'($urandom_range(1));
      if (r < 85) return 11'($urandom_range(2047, 1990));
      return 11'($urandom_range(2047));
   endfunction

   initial begin
      int          bound_idx[18];
      logic [2:0]  other_modes[5];
      logic [2:0]  m;
      bound_idx = '{0, 1, 2, 21, 22, 81, 82, 101, 102, 121, 122, 421, 422, 441, 442,
                    1999, 2000, 2047};
      other_modes = '{MODE_ZERO_DISABLED, MODE_ZERO_ENABLED, MODE_OFFSET_ENABLED,
                      MODE_CLEARED, MODE_UNDEFINED};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Echo waveform at full-scale amplitudes, every segment boundary.
      setting[REG_MODE] = {21'h0, MODE_ECHO};
      setting[REG_READOUT_AMP] = 24'h7FFFFF;
      setting[REG_PHASE_AMP] = 24'h800000;
      setting[REG_OFFSET_X] = 24'h800000;
      setting[REG_OFFSET_Y] = 24'h7FFFFF;
      setting[REG_OFFSET_Z] = 24'hFFFFFF;
      setting[REG_OFFSET_Z2] = 24'h000180;
      configure(1'b1);
      foreach (bound_idx[k]) send_index(11'(bound_idx[k]));
      drain();

      // Level and control words of the other tables.
      foreach (other_modes[k]) begin
         setting[REG_MODE] = {21'h0, other_modes[k]};
         configure(1'b0);
         send_index(11'd0);
         send_index(11'd1);
         drain();
      end

      for (int p = 0; p < NumPhases; p++) begin
         quiet = (p >= 10 && p < 14);
         m = ($urandom_range(99) < 60) ? MODE_ECHO : 3'($urandom_range(7));
         setting[REG_MODE] = {21'($urandom), m};
         for (int r = REG_READOUT_AMP; r <= REG_OFFSET_Z2; r++) setting[r] = pick_level();
         configure($urandom_range(3) == 0);
         repeat (ItemsPerPhase) send_index(pick_index());
         drain();
      end
      quiet = 1'b0;

      repeat (20) @(posedge clock);
      sb.close_out();
      $display("Checked %0d word sets over %0d register settings, echo mode in most.",
               sb.checked, settings_used);
      if (sb.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

/* filelist.f */
src/gtdac_pkg.sv
src/gtdac_decode.sv
src/gtdac_level.sv
src/gradient_trapezoid_dac_word_generator_top.sv
src/gtdac_checker.sv
tb/sv/gtdac_tb_pkg.sv
tb/sv/tb.sv
